FILE: src/b64se_pkg.sv
package b64se_pkg;

  // Group position codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Index of the last character of a record
  localparam logic [1:0] LAST_ONE   = 2'd0;
  localparam logic [1:0] LAST_TWO   = 2'd1;
  localparam logic [1:0] LAST_THREE = 2'd2;
  localparam logic [1:0] LAST_FOUR  = 2'd3;

  // Characters caused by one input byte, in emission order
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } push_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_stat_t;

  // Map a sextet onto the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    c = {2'b00, s};
    if (s < 6'd26) begin
      b64_char = 8'h41 + c;
    end else if (s < 6'd52) begin
      b64_char = 8'h61 + c - 8'd26;
    end else if (s < 6'd62) begin
      b64_char = 8'h30 + c - 8'd52;
    end else if (s == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

endpackage

FILE: src/b64se_in_if.sv
interface b64se_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
  modport monitor (input valid, input ready, input data_byte, input final_byte);
endinterface

FILE: src/b64se_out_if.sv
interface b64se_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink (input valid, input out_char, input run_last, output ready);
  modport monitor (input valid, input ready, input out_char, input run_last);
endinterface

FILE: src/b64se_front.sv
module b64se_front (
  input  logic             clk,
  input  logic             rst,
  b64se_in_if.sink         data,
  input  b64se_pkg::q_stat_t stat,
  output b64se_pkg::push_t wr
);
  import b64se_pkg::*;

  logic [3:0] carry;
  logic [1:0] phase;
  logic [3:0] carry_next;
  logic [1:0] phase_next;
  logic [3:0] mid_carry;
  logic [1:0] mid_phase;
  logic       accept;
  logic [7:0] b;

  assign data.ready = !stat.full;
  assign accept     = data.valid && data.ready;
  assign b          = data.data_byte;

  // Classify the byte by group position and build its character record
  always_comb begin
    wr.push         = accept;
    wr.rec.chars    = '0;
    wr.rec.last_idx = LAST_ONE;
    mid_carry       = '0;
    mid_phase       = PH_START;
    case (phase)
      PH_ONE: begin
        wr.rec.chars[0] = b64_char({carry[1:0], b[7:4]});
        mid_carry       = b[3:0];
        mid_phase       = PH_TWO;
      end
      PH_TWO: begin
        wr.rec.chars[0] = b64_char({carry[3:0], b[7:6]});
        wr.rec.chars[1] = b64_char(b[5:0]);
        wr.rec.last_idx = LAST_TWO;
        mid_carry       = '0;
        mid_phase       = PH_START;
      end
      default: begin
        wr.rec.chars[0] = b64_char(b[7:2]);
        mid_carry       = {2'b00, b[1:0]};
        mid_phase       = PH_ONE;
      end
    endcase

    carry_next = mid_carry;
    phase_next = mid_phase;

    // Flush leftover bits and pad on the final byte
    if (data.final_byte) begin
      case (mid_phase)
        PH_ONE: begin
          wr.rec.chars[1] = b64_char({mid_carry[1:0], 4'b0000});
          wr.rec.chars[2] = PAD_CHAR;
          wr.rec.chars[3] = PAD_CHAR;
          wr.rec.last_idx = LAST_FOUR;
        end
        PH_TWO: begin
          wr.rec.chars[1] = b64_char({mid_carry, 2'b00});
          wr.rec.chars[2] = PAD_CHAR;
          wr.rec.last_idx = LAST_THREE;
        end
        default: begin
        end
      endcase
      carry_next = '0;
      phase_next = PH_START;
    end
  end

  // Advance group state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= '0;
      phase <= PH_START;
    end else if (accept) begin
      carry <= carry_next;
      phase <= phase_next;
    end
  end

endmodule

FILE: src/b64se_queue.sv
module b64se_queue (
  input  logic                clk,
  input  logic                rst,
  input  b64se_pkg::push_t    wr,
  input  logic                pop,
  output b64se_pkg::q_stat_t  stat,
  output b64se_pkg::rec_t     head
);
  import b64se_pkg::*;

  localparam int DEPTH = 2;

  rec_t       mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign stat.full       = (count == 2'(DEPTH));
  assign stat.head_valid = (count != 2'd0);
  assign head            = mem[rd_ptr];

  // Store records, no reset needed on payload
  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.rec;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/b64se_back.sv
module b64se_back (
  input  logic               clk,
  input  logic               rst,
  input  b64se_pkg::q_stat_t stat,
  input  b64se_pkg::rec_t    head,
  output logic               pop,
  b64se_out_if.source        chars
);
  import b64se_pkg::*;

  logic       vld;
  logic [7:0] out_char;
  logic       run_last;
  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load           = stat.head_valid && (!vld || chars.ready);
  assign at_last        = (idx == head.last_idx);
  assign pop            = load && at_last;
  assign chars.valid    = vld;
  assign chars.out_char = out_char;
  assign chars.run_last = run_last;

  // Hold the output beat until taken, reload from the queue head
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        vld <= 1'b1;
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end else if (chars.ready) begin
        vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= head.chars[idx];
      run_last <= at_last;
    end
  end

endmodule

FILE: src/base64_stream_encoder.sv
// Channel | Modport | Beat payload
// data    | sink    | data_byte[7:0], final_byte
// chars   | source  | out_char[7:0], run_last
//
// A byte beat is taken every cycle the two-entry record queue has room.
// Each byte gives 1 to 4 character beats, one per cycle at the output
// register while chars.ready is high. Bytes pass the queue, then the register.
// Reset (rst, synchronous) clears group position, queue and output valid.
// Output stalls back up through the queue into data.ready.
module base64_stream_encoder (
  input  logic         clk,
  input  logic         rst,
  b64se_in_if.sink     data,
  b64se_out_if.source  chars
);
  import b64se_pkg::*;

  push_t   wr;
  q_stat_t stat;
  rec_t    head;
  logic    pop;

  b64se_front u_front (
    .clk  (clk),
    .rst  (rst),
    .data (data),
    .stat (stat),
    .wr   (wr)
  );

  b64se_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .stat (stat),
    .head (head)
  );

  b64se_back u_back (
    .clk   (clk),
    .rst   (rst),
    .stat  (stat),
    .head  (head),
    .pop   (pop),
    .chars (chars)
  );

endmodule

FILE: src/b64se_checker.sv
module b64se_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       run_last
);

  // Output beat holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char)
      && $stable(run_last))
    else $error("output beat dropped or changed while stalled");

  // A run continues without gaps until its last character
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside a character run");

  // Every accepted byte is followed by a valid output beat
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no output after accepted byte");

  // Only alphabet characters and padding appear
  a_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_char >= 8'h41 && out_char <= 8'h5A) ||
      (out_char >= 8'h61 && out_char <= 8'h7A) ||
      (out_char >= 8'h30 && out_char <= 8'h39) ||
      out_char == 8'h2B || out_char == 8'h2F ||
      out_char == 8'h3D)
    else $error("character outside alphabet");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (data.valid),
  .in_ready  (data.ready),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .out_char  (chars.out_char),
  .run_last  (chars.run_last)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import b64se_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;

  // Standard alphabet, index 0 in the top byte
  localparam logic [8*64-1:0] SEXTET_MAP =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_beat_t;

  logic clk;
  logic rst;
  logic out_ready = 1'b0;

  b64se_in_if  data_if ();
  b64se_out_if chars_if ();

  assign chars_if.ready = out_ready;

  base64_stream_encoder dut (
    .clk   (clk),
    .rst   (rst),
    .data  (data_if),
    .chars (chars_if)
  );

  // Predictor state
  logic [1:0] group_pos = PH_START;
  logic [3:0] carry_nib = 4'd0;
  char_beat_t expected_chars[$];

  // Idling controls
  bit src_idle       = 1'b1;
  int sink_stall_pct = 30;
  int stall_left     = 0;

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int messages_sent  = 0;
  int chars_checked  = 0;
  int idle_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    sextet_char = SEXTET_MAP[8*(63 - int'(s)) +: 8];
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Work out the characters one byte completes and queue them
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] seq [4];
    int         n;
    char_beat_t beat;
    n = 0;
    case (group_pos)
      PH_ONE: begin
        seq[n] = sextet_char({carry_nib[1:0], b[7:4]});
        n = n + 1;
        carry_nib = b[3:0];
        group_pos = PH_TWO;
      end
      PH_TWO: begin
        seq[n] = sextet_char({carry_nib, b[7:6]});
        n = n + 1;
        seq[n] = sextet_char(b[5:0]);
        n = n + 1;
        carry_nib = 4'd0;
        group_pos = PH_START;
      end
      default: begin
        seq[n] = sextet_char(b[7:2]);
        n = n + 1;
        carry_nib = {2'b00, b[1:0]};
        group_pos = PH_ONE;
      end
    endcase
    // Flush leftover bits and pad to a whole quad
    if (fin) begin
      if (group_pos == PH_ONE) begin
        seq[n] = sextet_char({carry_nib[1:0], 4'b0000});
        seq[n+1] = PAD_CHAR;
        seq[n+2] = PAD_CHAR;
        n = n + 3;
      end else if (group_pos == PH_TWO) begin
        seq[n] = sextet_char({carry_nib, 2'b00});
        seq[n+1] = PAD_CHAR;
        n = n + 2;
      end
      carry_nib = 4'd0;
      group_pos = PH_START;
    end
    for (int i = 0; i < n; i++) begin
      beat.code = seq[i];
      beat.last = (i == n - 1);
      expected_chars.insert(expected_chars.size(), beat);
    end
  endfunction

  // Output ready: random stalls, chained now and then
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= rand_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each character beat with the oldest expectation
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst && chars_if.valid && chars_if.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual char %h last %b",
                 $time, chars_if.out_char, chars_if.run_last);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = expected_chars.pop_front();
        chars_checked = chars_checked + 1;
        if (chars_if.out_char !== want.code) begin
          $display("%0t: out_char mismatch: expected %h, actual %h",
                   $time, want.code, chars_if.out_char);
          mismatch_count = mismatch_count + 1;
        end
        if (chars_if.run_last !== want.last) begin
          $display("%0t: run_last mismatch: expected %b, actual %b",
                   $time, want.last, chars_if.run_last);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (data_if.valid && data_if.ready) || (chars_if.valid && chars_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d beats outstanding",
               $time, expected_chars.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one byte beat and hold it until taken; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = src_idle ? rand_gap() : 0;
    if (gap != 0) begin
      data_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_if.valid <= 1'b1;
    data_if.data_byte <= b;
    data_if.final_byte <= fin;
    do begin
      @(posedge clk);
    end while (!(data_if.valid && data_if.ready));
    encode_byte(b, fin);
    bytes_sent = bytes_sent + 1;
    if (fin) messages_sent = messages_sent + 1;
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  // Drop valid and hold until every queued character has come out
  task automatic drain_chars();
    data_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  function automatic int rand_msg_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 1;
    if (r < 65) return $urandom_range(2, 6);
    if (r < 90) return $urandom_range(7, 15);
    return $urandom_range(16, 40);
  endfunction

  // Extremes, every group position at the final byte, known strings
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);
    // one of the top two alphabet entries in every sextet slot
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    drain_chars();
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    int start;
    src_idle = 1'b0;
    sink_stall_pct = 0;
    start = bytes_sent;
    while (bytes_sent - start < 60) send_message($urandom_range(1, 8));
    drain_chars();
    src_idle = 1'b1;
    sink_stall_pct = 30;
  endtask

  // Receiver mostly stalled, so the queue backs up into the input
  task automatic test_sink_backpressure();
    int start;
    sink_stall_pct = 75;
    start = bytes_sent;
    while (bytes_sent - start < 40) send_message($urandom_range(1, 5));
    drain_chars();
    sink_stall_pct = 30;
  endtask

  // Random messages; now and then hold off until the output drains
  task automatic test_random_messages();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 360) begin
      send_message(rand_msg_len());
      if ($urandom_range(0, 9) == 0) drain_chars();
    end
    drain_chars();
  endtask

  initial begin
    rst = 1'b1;
    data_if.valid = 1'b0;
    data_if.data_byte = 8'h00;
    data_if.final_byte = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_sink_backpressure();
    test_random_messages();

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Encoded %0d bytes in %0d messages, %0d characters checked,",
             bytes_sent, messages_sent, chars_checked);
    $display("with random gaps, back-to-back beats and heavy output stalls.");
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
